// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the divider and the queue of the propagator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset has been released.
`define CTRV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ctrv assertion failed");

// Checked on every rising edge, reset included.
`define CTRV_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ctrv assertion failed");

`endif

// ===== sv/ctrv_pkg.sv =====
`timescale 1ns / 1ps

package ctrv_pkg;

    localparam int CNT_W         = 11;
    localparam int CORDIC_ITERS  = 24;
    localparam int SUBSTEP_FLOOR = 66;
    localparam longint CORDIC_GAIN_Q30 = 64'd652032874;

    localparam logic [1:0] REG_MAX_HORIZON = 2'd0;
    localparam logic [1:0] REG_TURN_FLOOR  = 2'd1;
    localparam logic [1:0] REG_SUBSTEP     = 2'd2;

    localparam logic [31:0] ATAN_TURN [0:CORDIC_ITERS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] speed;
        logic signed [23:0] turn_rate;
        logic signed [23:0] horizon;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [15:0] new_heading;
        logic               steps_clamped;
    } out_item_t;

    typedef struct packed {
        logic [22:0] max_horizon;
        logic [22:0] turn_rate_floor;
        logic [22:0] substep_limit;
    } cfg_t;

    // One propagation job; a step count of zero means the pose passes through.
    typedef struct packed {
        logic [31:0]       pos_x;
        logic [31:0]       pos_y;
        logic [15:0]       heading;
        logic signed [15:0] speed;
        logic [30:0]       step;
        logic [31:0]       dyaw;
        logic [CNT_W-1:0]  count;
        logic              clamped;
    } job_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [23:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/ctrv_div.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctrv_div (
    input  logic                clk,
    input  logic                rst_n,
    input  ctrv_pkg::div_req_t  req,
    output ctrv_pkg::div_rsp_t  rsp
);

    logic [31:0] q_reg, q_next;
    logic [23:0] dsr_reg, dsr_next;
    logic [23:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] shifted;
    logic        fits;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        shifted   = {rem_reg, q_reg[31]};
        fits      = shifted >= {1'b0, dsr_reg};
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            q_next    = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so 24 bits always hold it.
            rem_next = fits ? 24'(shifted - {1'b0, dsr_reg}) : shifted[23:0];
            q_next   = {q_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    `CTRV_ASSERT(a_div_start_idle, req.start |-> !busy_reg)

endmodule

// ===== sv/ctrv_front.sv =====
`timescale 1ns / 1ps

module ctrv_front #(
    parameter int MAX_SUBSTEPS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ctrv_pkg::in_item_t  in_data,
    input  ctrv_pkg::cfg_t      cfg,
    output logic                job_push,
    output ctrv_pkg::job_t      job_data,
    input  logic                job_full,
    output ctrv_pkg::div_req_t  div_req,
    input  ctrv_pkg::div_rsp_t  div_rsp
);

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_DIVN  = 5'b00010,
        F_DIVS  = 5'b00100,
        F_MUL   = 5'b01000,
        F_PUSH  = 5'b10000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [31:0]        px_reg, py_reg;
    logic [15:0]        hd_reg;
    logic signed [15:0] spd_reg;
    logic [22:0]        dt_reg;
    logic signed [23:0] w_reg;
    logic [30:0]        step_reg;
    logic [31:0]        dyaw_reg;
    logic [ctrv_pkg::CNT_W-1:0] n_reg;
    logic               clamp_reg;

    logic               accept;
    logic               propagate;
    logic [22:0]        dt_clamped;
    logic [23:0]        abs_w;
    logic signed [23:0] w_eff;
    logic [22:0]        sub_len;
    logic [23:0]        ceil_num;
    logic               n_sat;
    logic [ctrv_pkg::CNT_W-1:0] n_val;
    logic signed [55:0] dyaw_prod;

    assign accept    = in_valid && (state_reg == F_IDLE);
    assign in_stall  = state_reg != F_IDLE;
    assign propagate = !in_data.horizon[23] && (in_data.horizon != 24'sd0);

    always_comb
    begin
        dt_clamped = (in_data.horizon[22:0] > cfg.max_horizon) ? cfg.max_horizon
                                                              : in_data.horizon[22:0];
        abs_w   = in_data.turn_rate[23] ? 24'(-in_data.turn_rate) : in_data.turn_rate;
        w_eff   = (abs_w < {1'b0, cfg.turn_rate_floor}) ? 24'sd0 : in_data.turn_rate;
        sub_len = (cfg.substep_limit < 23'(ctrv_pkg::SUBSTEP_FLOOR))
                  ? 23'(ctrv_pkg::SUBSTEP_FLOOR) : cfg.substep_limit;
        ceil_num = {1'b0, dt_clamped} + {1'b0, sub_len} - 24'd1;
        n_sat    = div_rsp.quotient > 32'(MAX_SUBSTEPS);
        if (n_sat)
            n_val = ctrv_pkg::CNT_W'(MAX_SUBSTEPS);
        else if (div_rsp.quotient == 32'd0)
            n_val = ctrv_pkg::CNT_W'(1);
        else
            n_val = div_rsp.quotient[ctrv_pkg::CNT_W-1:0];
        dyaw_prod = $signed(w_reg) * $signed({1'b0, step_reg});
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {8'd0, ceil_num};
        div_req.divisor  = {1'b0, sub_len};
        if (state_reg == F_DIVN)
        begin
            div_req.start    = div_rsp.done;
            div_req.dividend = {1'b0, dt_reg, 8'd0};
            div_req.divisor  = 24'(n_val);
        end
        else
        begin
            div_req.start = accept && propagate;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (accept) state_next = propagate ? F_DIVN : F_PUSH;
            F_DIVN: if (div_rsp.done) state_next = F_DIVS;
            F_DIVS: if (div_rsp.done) state_next = F_MUL;
            F_MUL:  state_next = F_PUSH;
            F_PUSH: if (!job_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= in_data.pos_x;
            py_reg    <= in_data.pos_y;
            hd_reg    <= in_data.heading;
            spd_reg   <= in_data.speed;
            dt_reg    <= dt_clamped;
            w_reg     <= w_eff;
            n_reg     <= '0;
            clamp_reg <= 1'b0;
            step_reg  <= '0;
            dyaw_reg  <= '0;
        end
        if (state_reg == F_DIVN && div_rsp.done)
        begin
            n_reg     <= n_val;
            clamp_reg <= n_sat;
        end
        if (state_reg == F_DIVS && div_rsp.done)
            step_reg <= div_rsp.quotient[30:0];
        if (state_reg == F_MUL)
            dyaw_reg <= dyaw_prod[47:16];
    end

    assign job_push         = (state_reg == F_PUSH) && !job_full;
    assign job_data.pos_x   = px_reg;
    assign job_data.pos_y   = py_reg;
    assign job_data.heading = hd_reg;
    assign job_data.speed   = spd_reg;
    assign job_data.step    = step_reg;
    assign job_data.dyaw    = dyaw_reg;
    assign job_data.count   = n_reg;
    assign job_data.clamped = clamp_reg;

endmodule

// ===== sv/ctrv_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctrv_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ctrv_pkg::job_t  wr_data,
    output logic            full,
    input  logic            pop,
    output ctrv_pkg::job_t  rd_data,
    output logic            empty
);

    ctrv_pkg::job_t mem_reg [0:1];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_data;
    end

    `CTRV_ASSERT(a_no_overflow, push |-> !full)
    `CTRV_ASSERT(a_no_underflow, pop |-> !empty)
    `CTRV_ASSERT_ALWAYS(a_count_range, cnt_reg != 2'd3)

endmodule

// ===== sv/ctrv_back.sv =====
`timescale 1ns / 1ps

module ctrv_back #(
    parameter int TRIG_FRACTION_BITS = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  ctrv_pkg::job_t      job_data,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output ctrv_pkg::out_item_t out_data
);

    localparam int CW = TRIG_FRACTION_BITS + 3;
    localparam int VW = 27;
    localparam int SW = 16 + CW;
    localparam logic [63:0] X0 = 64'(ctrv_pkg::CORDIC_GAIN_Q30 >> (30 - TRIG_FRACTION_BITS));

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_LOAD = 7'b0000010,
        B_ROT  = 7'b0000100,
        B_VEL  = 7'b0001000,
        B_POS  = 7'b0010000,
        B_ADD  = 7'b0100000,
        B_DONE = 7'b1000000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [31:0]        x_reg, y_reg, yaw_reg, dyaw_reg;
    logic signed [15:0] spd_reg;
    logic [30:0]        step_reg;
    logic [ctrv_pkg::CNT_W-1:0] k_reg;
    logic               clamp_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [32:0] z_reg;
    logic [4:0]         it_reg;
    logic [1:0]         quad_reg;
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic [31:0]        ix_reg, iy_reg;
    logic               out_valid_reg;
    ctrv_pkg::out_item_t out_reg;

    logic [31:0]        yaw_off;
    logic [31:0]        z_start;
    logic signed [CW-1:0] dx, dy, cos_v, sin_v;
    logic signed [32:0] atan_v;
    logic signed [SW-1:0] pvx, pvy;
    logic signed [VW+31:0] pix, piy;
    logic               out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign job_pop  = (state_reg == B_IDLE) && !job_empty;

    always_comb
    begin
        yaw_off = yaw_reg + 32'h4000_0000;
        z_start = yaw_reg - {yaw_off[31:30], 30'd0};
        dx      = cy_reg >>> it_reg;
        dy      = cx_reg >>> it_reg;
        atan_v  = $signed({1'b0, ctrv_pkg::ATAN_TURN[it_reg]});
        case (quad_reg)
            2'd0:
            begin
                cos_v = cx_reg;
                sin_v = cy_reg;
            end
            2'd1:
            begin
                cos_v = -cy_reg;
                sin_v = cx_reg;
            end
            2'd2:
            begin
                cos_v = -cx_reg;
                sin_v = -cy_reg;
            end
            default:
            begin
                cos_v = cy_reg;
                sin_v = -cx_reg;
            end
        endcase
        pvx = spd_reg * cos_v;
        pvy = spd_reg * sin_v;
        pix = vx_reg * $signed({1'b0, step_reg});
        piy = vy_reg * $signed({1'b0, step_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!job_empty)
                    state_next = (job_data.count == '0) ? B_DONE : B_LOAD;
            B_LOAD: state_next = B_ROT;
            B_ROT:
                if (it_reg == 5'(ctrv_pkg::CORDIC_ITERS - 1))
                    state_next = B_VEL;
            B_VEL:  state_next = B_POS;
            B_POS:  state_next = B_ADD;
            B_ADD:  state_next = (k_reg == ctrv_pkg::CNT_W'(1)) ? B_DONE : B_LOAD;
            B_DONE: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                x_reg     <= job_data.pos_x;
                y_reg     <= job_data.pos_y;
                yaw_reg   <= {job_data.heading, 16'd0};
                dyaw_reg  <= job_data.dyaw;
                spd_reg   <= job_data.speed;
                step_reg  <= job_data.step;
                k_reg     <= job_data.count;
                clamp_reg <= job_data.clamped;
            end
            B_LOAD:
            begin
                // Fold the angle into the quarter turn centred on the quadrant.
                quad_reg <= yaw_off[31:30];
                z_reg    <= {z_start[31], z_start};
                cx_reg   <= CW'(X0);
                cy_reg   <= '0;
                it_reg   <= '0;
            end
            B_ROT:
            begin
                if (!z_reg[32])
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + atan_v;
                end
                it_reg <= it_reg + 5'd1;
            end
            B_VEL:
            begin
                vx_reg <= pvx[SW-1:TRIG_FRACTION_BITS-8];
                vy_reg <= pvy[SW-1:TRIG_FRACTION_BITS-8];
            end
            B_POS:
            begin
                ix_reg <= pix[55:24];
                iy_reg <= piy[55:24];
            end
            B_ADD:
            begin
                x_reg   <= x_reg + ix_reg;
                y_reg   <= y_reg + iy_reg;
                yaw_reg <= yaw_reg + dyaw_reg;
                k_reg   <= k_reg - ctrv_pkg::CNT_W'(1);
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_reg.new_x         <= x_reg;
                    out_reg.new_y         <= y_reg;
                    out_reg.new_heading   <= yaw_reg[31:16];
                    out_reg.steps_clamped <= clamp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/ctrv_motion_propagator_core.sv =====
`timescale 1ns / 1ps

// Propagates a pose over a time horizon with a constant-speed, constant-turn-rate model
// in forward-Euler sub-steps. The front takes one item at a time and runs two serial
// 32-bit divisions (sub-step count, then sub-step length) and a yaw multiply; a two-entry
// queue hands the job to the back, which runs each sub-step as its 24-iteration CORDIC
// followed by two multiply stages (a non-positive horizon skips the divisions and the
// sub-steps). The front can prepare the next beat while the back is busy, and a finished
// result sits in an output register. The user must write configuration registers only
// while the block is idle; the block itself does not enforce it.
module ctrv_motion_propagator_core #(
    parameter int MAX_SUBSTEPS       = 64,
    parameter int TRIG_FRACTION_BITS = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ctrv_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ctrv_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [22:0]         cfg_data
);

    ctrv_pkg::cfg_t     cfg_reg;
    ctrv_pkg::div_req_t div_req;
    ctrv_pkg::div_rsp_t div_rsp;
    ctrv_pkg::job_t     push_data, pop_data;
    logic               push, pop, full, empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_horizon     <= 23'd196608;
            cfg_reg.turn_rate_floor <= 23'd256;
            cfg_reg.substep_limit   <= 23'd6554;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ctrv_pkg::REG_MAX_HORIZON: cfg_reg.max_horizon     <= cfg_data;
                ctrv_pkg::REG_TURN_FLOOR:  cfg_reg.turn_rate_floor <= cfg_data;
                ctrv_pkg::REG_SUBSTEP:     cfg_reg.substep_limit   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ctrv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ctrv_front #(
        .MAX_SUBSTEPS (MAX_SUBSTEPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .job_push (push),
        .job_data (push_data),
        .job_full (full),
        .div_req  (div_req),
        .div_rsp  (div_rsp)
    );

    ctrv_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .full    (full),
        .pop     (pop),
        .rd_data (pop_data),
        .empty   (empty)
    );

    ctrv_back #(
        .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (empty),
        .job_data  (pop_data),
        .job_pop   (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== tb/sv/tb_ctrv_motion_propagator_core.sv =====
`timescale 1ns / 1ps

module tb_ctrv_motion_propagator_core;

    localparam int MAX_STEPS = 64;
    localparam int TRIG_FB   = 15;
    localparam int STALL_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    ctrv_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    ctrv_pkg::out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [22:0] cfg_data;

    ctrv_motion_propagator_core #(
        .MAX_SUBSTEPS(MAX_STEPS),
        .TRIG_FRACTION_BITS(TRIG_FB)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor's copy of the configuration.
    logic [22:0] horizon_cap;
    logic [22:0] yaw_floor;
    logic [22:0] substep_cap;

    ctrv_pkg::in_item_t  pose_queue[$];
    ctrv_pkg::out_item_t pose_expected[$];
    ctrv_pkg::out_item_t predicted;

    int mismatches = 0;
    int poses_sent = 0;
    int poses_checked = 0;
    int clamped_seen = 0;
    int idle_cycles = 0;
    bit hold_sender = 0;
    bit timed_out = 0;

    always #2 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    task automatic turn_sincos(input logic [31:0] ang, output longint c, output longint s);
        logic [1:0]  quad;
        logic [31:0] rest;
        longint z;
        longint xr;
        longint yr;
        longint dx;
        longint dy;
        quad = 2'((ang + 32'h40000000) >> 30);
        rest = ang - ({30'd0, quad} << 30);
        z  = longint'($signed(rest));
        xr = ctrv_pkg::CORDIC_GAIN_Q30 >>> (30 - TRIG_FB);
        yr = 0;
        for (int i = 0; i < ctrv_pkg::CORDIC_ITERS; i++)
        begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (z >= 0)
            begin
                xr = xr - dx;
                yr = yr + dy;
                z  = z - longint'(ctrv_pkg::ATAN_TURN[i]);
            end
            else
            begin
                xr = xr + dx;
                yr = yr - dy;
                z  = z + longint'(ctrv_pkg::ATAN_TURN[i]);
            end
        end
        case (quad)
            2'd0: begin c = xr;  s = yr;  end
            2'd1: begin c = -yr; s = xr;  end
            2'd2: begin c = -xr; s = -yr; end
            default: begin c = yr; s = -xr; end
        endcase
    endtask

    task automatic propagate_pose(input ctrv_pkg::in_item_t p,
                                  output ctrv_pkg::out_item_t r);
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] yaw;
        longint dt;
        longint w;
        longint sp;
        longint sub;
        longint n;
        longint step;
        longint dyaw;
        longint c;
        longint s;
        longint vx;
        longint vy;
        px = p.pos_x;
        py = p.pos_y;
        dt = p.horizon;
        w  = p.turn_rate;
        sp = p.speed;
        r.steps_clamped = 1'b0;
        r.new_heading = p.heading;
        if (dt > 0)
        begin
            sub = (substep_cap < ctrv_pkg::SUBSTEP_FLOOR) ? ctrv_pkg::SUBSTEP_FLOOR
                                                          : longint'(substep_cap);
            yaw = {p.heading, 16'd0};
            if (dt > longint'(horizon_cap))
                dt = horizon_cap;
            if ((w < 0 ? -w : w) < longint'(yaw_floor))
                w = 0;
            n = (dt + sub - 1) / sub;
            if (n < 1)
                n = 1;
            if (n > MAX_STEPS)
            begin
                n = MAX_STEPS;
                r.steps_clamped = 1'b1;
            end
            step = (dt * 256) / n;
            dyaw = floor_shift(w * step, 16);
            for (longint k = 0; k < n; k++)
            begin
                turn_sincos(yaw, c, s);
                vx = floor_shift(sp * c, TRIG_FB - 8);
                vy = floor_shift(sp * s, TRIG_FB - 8);
                px = px + 32'(floor_shift(vx * step, 24));
                py = py + 32'(floor_shift(vy * step, 24));
                yaw = yaw + 32'(dyaw);
            end
            r.new_heading = yaw[31:16];
        end
        r.new_x = px;
        r.new_y = py;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, poses_checked);
        mismatches++;
    endtask

    // Sender: bursts of random length, sometimes separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (!(in_valid && in_stall))
            begin
                if (in_valid)
                begin
                    propagate_pose(in_data, predicted);
                    pose_expected.push_back(predicted);
                    poses_sent++;
                end
                if (gap_left > 0 || hold_sender || pose_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= pose_queue.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(8, 1);
                        if ($urandom_range(2, 0) == 0)
                            gap_left <= $urandom_range(40, 1);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stalls at random in part of each period; the rest of the period has no stall at all.
    int stall_phase = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(3, 0) == 0);
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                idle_cycles <= 0;
                if (pose_expected.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    ctrv_pkg::out_item_t want;
                    want = pose_expected.pop_front();
                    if (out_data.new_x !== want.new_x)
                        report_mismatch("new_x", out_data.new_x, want.new_x);
                    if (out_data.new_y !== want.new_y)
                        report_mismatch("new_y", out_data.new_y, want.new_y);
                    if (out_data.new_heading !== want.new_heading)
                        report_mismatch("new_heading", out_data.new_heading,
                                        want.new_heading);
                    if (out_data.steps_clamped !== want.steps_clamped)
                        report_mismatch("steps_clamped", out_data.steps_clamped,
                                        want.steps_clamped);
                    if (want.steps_clamped)
                        clamped_seen++;
                end
                poses_checked++;
            end
            else if (in_valid && !in_stall)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT && !timed_out)
            begin
                timed_out = 1;
                $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
                $display("ctrv_motion_propagator_core test failed");
                $finish;
            end
        end
    end

    function automatic ctrv_pkg::in_item_t random_pose(input bit tidy);
        ctrv_pkg::in_item_t p;
        p.pos_x = $urandom;
        p.pos_y = $urandom;
        p.heading = 16'($urandom);
        p.speed = 16'($urandom);
        p.turn_rate = 24'($urandom);
        p.horizon = 24'($urandom);
        if (tidy)
        begin
            // Mostly short positive horizons so most items run a few sub-steps.
            case ($urandom_range(9, 0))
                0: p.horizon = -$signed({1'b0, 23'($urandom_range(1000, 0))});
                1: p.horizon = 24'($urandom_range(24'h7FFFFF, 1));
                2: p.turn_rate = 24'(int'($urandom_range(600, 0)) - 300);
                default: p.horizon = 24'($urandom_range(30000, 1));
            endcase
            if ($urandom_range(1, 0))
                p.speed = 16'(int'($urandom_range(8000, 0)) - 4000);
        end
        return p;
    endfunction

    task automatic wait_drained;
        while (pose_queue.size() != 0 || in_valid || pose_expected.size() != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [22:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ctrv_pkg::REG_MAX_HORIZON: horizon_cap = val;
            ctrv_pkg::REG_TURN_FLOOR:  yaw_floor = val;
            ctrv_pkg::REG_SUBSTEP:     substep_cap = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_pose(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [15:0] h, input logic signed [15:0] v,
                            input logic signed [23:0] w, input logic signed [23:0] dt);
        ctrv_pkg::in_item_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.heading = h;
        p.speed = v;
        p.turn_rate = w;
        p.horizon = dt;
        pose_queue.push_back(p);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = ctrv_pkg::REG_MAX_HORIZON;
        cfg_data = '0;
        horizon_cap = 23'd196608;
        yaw_floor = 23'd256;
        substep_cap = 23'd6554;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, pass-through, floor on turn rate, saturation.
        add_pose(0, 0, 0, 16'sd256, 0, 24'sd65536);
        add_pose(32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF);
        add_pose(32'h80000000, 32'h7FFFFFFF, 16'h8000, 16'h8000, 24'h800000, 24'sd1);
        add_pose(123, 456, 16'sd1000, 16'sd512, 24'sd5000, 0);
        add_pose(123, 456, 16'sd1000, 16'sd512, 24'sd5000, 24'h800000);
        add_pose(-5, 7, 16'sd16384, 16'sd300, 24'sd255, 24'sd40000);
        add_pose(-5, 7, 16'sd16384, 16'sd300, -24'sd255, 24'sd40000);
        add_pose(-5, 7, -16'sd16384, 16'sd300, 24'sd256, 24'sd40000);
        add_pose(0, 0, 16'h7FFF, -16'sd1000, -24'sd9000, 24'sd196608);
        add_pose(0, 0, -16'sd32768, 16'sd1, 24'sd1000000, 24'sd6554);
        add_pose(-1, -1, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'sd6555);
        wait_drained();

        // Tiny sub-step forces count saturation; max horizon of zero gives a
        // single empty sub-step.
        write_reg(ctrv_pkg::REG_SUBSTEP, 23'd0);
        write_reg(ctrv_pkg::REG_TURN_FLOOR, 23'h7FFFFF);
        add_pose(10, 20, 16'sd3000, 16'sd2000, 24'sd70000, 24'sd100000);
        add_pose(10, 20, 16'sd3000, 16'sd2000, 24'sd70000, 24'sd65);
        add_pose(10, 20, 16'sd3000, 16'sd2000, 24'sd70000, 24'sd67);
        wait_drained();
        write_reg(ctrv_pkg::REG_MAX_HORIZON, 23'd0);
        write_reg(ctrv_pkg::REG_TURN_FLOOR, 23'd0);
        add_pose(10, 20, 16'sd3000, 16'sd2000, 24'sd70000, 24'sd100000);
        add_pose(-10, 2, -16'sd3000, -16'sd2000, 24'sd1, 24'sd1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin
                    write_reg(ctrv_pkg::REG_MAX_HORIZON, 23'h7FFFFF);
                    write_reg(ctrv_pkg::REG_SUBSTEP, 23'h7FFFFF);
                    write_reg(ctrv_pkg::REG_TURN_FLOOR, 23'd256);
                end
                1: begin
                    write_reg(ctrv_pkg::REG_MAX_HORIZON, 23'd196608);
                    write_reg(ctrv_pkg::REG_SUBSTEP, 23'd6554);
                end
                2: begin
                    write_reg(ctrv_pkg::REG_SUBSTEP, 23'd66);
                    write_reg(ctrv_pkg::REG_MAX_HORIZON, 23'd8000);
                    write_reg(ctrv_pkg::REG_TURN_FLOOR, 23'd2000);
                end
                default: begin
                    write_reg(ctrv_pkg::REG_MAX_HORIZON, 23'($urandom));
                    write_reg(ctrv_pkg::REG_SUBSTEP, 23'($urandom_range(20000, 0)));
                    write_reg(ctrv_pkg::REG_TURN_FLOOR, 23'($urandom));
                end
            endcase
            for (int i = 0; i < 120; i++)
                pose_queue.push_back(random_pose($urandom_range(7, 0) != 0));
            if (phase == 1)
            begin
                // Let the block empty completely before the rest of this phase.
                while (pose_queue.size() > 60)
                    @(posedge clk);
                hold_sender = 1;
                while (in_valid || pose_expected.size() != 0)
                    @(posedge clk);
                hold_sender = 0;
            end
            wait_drained();
        end

        $display("propagated %0d poses over several register settings, %0d checked",
                 poses_sent, poses_checked);
        $display("%0d results reported sub-step saturation", clamped_seen);
        if (mismatches == 0)
            $display("ctrv_motion_propagator_core test passed");
        else
            $display("ctrv_motion_propagator_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ctrv_pkg.sv
sv/ctrv_div.sv
sv/ctrv_front.sv
sv/ctrv_fifo.sv
sv/ctrv_back.sv
sv/ctrv_motion_propagator_core.sv
tb/sv/tb_ctrv_motion_propagator_core.sv
